// ----- hw/rtl/critically_damped_smoother_unit_defines.svh -----
// Assertion macros for the critically damped smoother.
// Pulled in by the RTL files that carry checks; no other dependencies.
`ifndef CRITICALLY_DAMPED_SMOOTHER_UNIT_DEFINES_SVH
`define CRITICALLY_DAMPED_SMOOTHER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CDS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- hw/rtl/cds_pkg.sv -----
// Shared types, constants and saturating helpers for the smoother.
// No dependencies; used by the interfaces, the arithmetic units and the top level.
package cds_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // intermediate fixed point word
    localparam int Q_W = 64;
    localparam int VEL_W = 48;
    localparam int POS_W = 32;
    localparam int TIME_W = 32;

    localparam logic signed [Q_W-1:0] LIM_Q = {2'b00, {(Q_W-2){1'b1}}};

    localparam logic OP_SET = 1'b0;
    localparam logic OP_ADV = 1'b1;

    typedef struct packed {
        logic                    op;
        logic signed [POS_W-1:0] start_pos;
        logic signed [POS_W-1:0] goal_pos;
        logic                    clear_velocity;
        logic [TIME_W-1:0]       elapsed;
    } t_in_word;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
    } t_out_word;

    // clamp a widened sum to +-LIM_Q
    function automatic logic signed [Q_W-1:0] qsat(input logic signed [Q_W:0] s);
        logic signed [Q_W:0] lim;
        lim = $signed({1'b0, LIM_Q});
        if (s > lim) begin
            return LIM_Q;
        end else if (s < -lim) begin
            return -LIM_Q;
        end
        return $signed(s[Q_W-1:0]);
    endfunction

    function automatic logic signed [Q_W-1:0] qadd(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        return qsat($signed({a[Q_W-1], a}) + $signed({b[Q_W-1], b}));
    endfunction

    function automatic logic signed [Q_W-1:0] qsub(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        return qsat($signed({a[Q_W-1], a}) - $signed({b[Q_W-1], b}));
    endfunction

    function automatic logic [Q_W-1:0] qabs(input logic signed [Q_W-1:0] a);
        return a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
    endfunction

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] hi;
        logic signed [Q_W-1:0] lo;
        hi = $signed({{(Q_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}});
        lo = $signed({{(Q_W-VEL_W+1){1'b1}}, {(VEL_W-1){1'b0}}});
        if (v > hi) begin
            return $signed({1'b0, {(VEL_W-1){1'b1}}});
        end else if (v < lo) begin
            return $signed({1'b1, {(VEL_W-1){1'b0}}});
        end
        return $signed(v[VEL_W-1:0]);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] hi;
        logic signed [Q_W-1:0] lo;
        hi = $signed({{(Q_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}});
        lo = $signed({{(Q_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}});
        if (v > hi) begin
            return $signed({1'b0, {(POS_W-1){1'b1}}});
        end else if (v < lo) begin
            return $signed({1'b1, {(POS_W-1){1'b0}}});
        end
        return $signed(v[POS_W-1:0]);
    endfunction

    // negate velocity; the most negative value saturates
    function automatic logic signed [VEL_W-1:0] vel_neg(input logic signed [VEL_W-1:0] v);
        if (v == $signed({1'b1, {(VEL_W-1){1'b0}}})) begin
            return $signed({1'b0, {(VEL_W-1){1'b1}}});
        end
        return -v;
    endfunction

endpackage

// ----- hw/rtl/cds_ifs.sv -----
// Valid/ready channel interfaces for the smoother: input words, results, config writes.
// Depends on cds_pkg for the payload types.
interface cds_in_if;
    logic               valid;
    logic               ready;
    cds_pkg::t_in_word  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cds_out_if;
    logic               valid;
    logic               ready;
    cds_pkg::t_out_word data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface cds_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [cds_pkg::TIME_W-1:0]   data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- hw/rtl/cds_mul.sv -----
// Sequential saturating Q multiplier: one 32x32 partial product per cycle.
// Depends on cds_pkg and the assertion macro header.
`include "critically_damped_smoother_unit_defines.svh"
module cds_mul #(
    parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [cds_pkg::Q_W-1:0]  i_a,
    input  logic signed [cds_pkg::Q_W-1:0]  i_b,
    output logic                            o_done,
    output logic signed [cds_pkg::Q_W-1:0]  o_result
);
    import cds_pkg::*;

    localparam int HALF_W = Q_W / 2;
    localparam int PROD_W = 2 * Q_W;
    // product bits at and above this index mean the shifted value exceeds LIM_Q
    localparam int SAT_LSB = Q_W - 2 + FRAC_BITS;

    logic                    r_busy;
    logic                    r_fin;
    logic                    r_done;
    logic [1:0]              r_step;
    logic                    r_neg;
    logic [Q_W-1:0]          r_ua;
    logic [Q_W-1:0]          r_ub;
    logic [PROD_W-1:0]       r_acc;
    logic signed [Q_W-1:0]   r_result;

    logic [HALF_W-1:0]       w_pa;
    logic [HALF_W-1:0]       w_pb;
    logic [Q_W-1:0]          w_pp;
    logic [PROD_W-1:0]       w_pp_ext;
    logic                    w_sat;
    logic [Q_W-1:0]          w_mag;

    assign w_pa = r_step[1] ? r_ua[Q_W-1:HALF_W] : r_ua[HALF_W-1:0];
    assign w_pb = r_step[0] ? r_ub[Q_W-1:HALF_W] : r_ub[HALF_W-1:0];
    assign w_pp = w_pa * w_pb;

    always_comb begin
        case (r_step)
            2'd0:    w_pp_ext = {{Q_W{1'b0}}, w_pp};
            2'd3:    w_pp_ext = {w_pp, {Q_W{1'b0}}};
            default: w_pp_ext = {{HALF_W{1'b0}}, w_pp, {HALF_W{1'b0}}};
        endcase
    end

    assign w_sat = |r_acc[PROD_W-1:SAT_LSB];
    assign w_mag = w_sat ? Q_W'(LIM_Q) : {2'b00, r_acc[SAT_LSB-1:FRAC_BITS]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= qabs(i_a);
            r_ub  <= qabs(i_b);
            r_neg <= i_a[Q_W-1] ^ i_b[Q_W-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp_ext;
        end
        if (r_fin) begin
            r_result <= r_neg ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `CDS_ASSERT(a_mul_start_idle, i_clk, i_rst_n, (i_start |-> !r_busy && !r_fin && !r_done), "mul started while busy")
    `CDS_ASSERT(a_mul_last_step, i_clk, i_rst_n, (r_busy && r_step == 2'd3 && !i_start |=> r_fin && !r_busy), "mul missed final step")
    `CDS_ASSERT(a_mul_done_pulse, i_clk, i_rst_n, (r_done |=> !r_done), "mul done held")

endmodule

// ----- hw/rtl/cds_div.sv -----
// Restoring divider, one quotient bit per cycle, for the two reciprocals.
// Depends on cds_pkg and the assertion macro header.
`include "critically_damped_smoother_unit_defines.svh"
module cds_div #(
    parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF,
    parameter int DVD_W     = 2 * FRAC_BITS + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [DVD_W-1:0]            i_dividend,
    input  logic [cds_pkg::Q_W-1:0]     i_divisor,
    output logic                        o_done,
    output logic [DVD_W-1:0]            o_quot
);
    import cds_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [Q_W-1:0]     r_rem;
    logic [Q_W-1:0]     r_dvs;
    logic [DVD_W-1:0]   r_q;

    logic [Q_W-1:0]     w_trial;
    logic               w_ge;

    // remainder stays below the divisor (< 2^63), so its top bit is free
    assign w_trial = {r_rem[Q_W-2:0], r_q[DVD_W-1]};
    assign w_ge    = (w_trial >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - r_dvs) : w_trial;
            r_q   <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    `CDS_ASSERT(a_div_start_idle, i_clk, i_rst_n, (i_start |-> !r_busy && !r_done), "div started while busy")
    `CDS_ASSERT(a_div_last_bit, i_clk, i_rst_n, (r_busy && r_cnt == CNT_W'(1) && !i_start |=> r_done && !r_busy), "div missed final bit")
    `CDS_ASSERT(a_div_done_pulse, i_clk, i_rst_n, (r_done |=> !r_done), "div done held")

endmodule

// ----- hw/rtl/critically_damped_smoother_unit.sv -----
// Critically damped spring smoother, one axis, Q fixed point with FRAC_BITS fraction bits.
// i_in takes one word per operation: op 0 loads start and goal (velocity cleared or negated
// on a direction flip), op 1 advances by elapsed time. Every word yields one word on o_out
// carrying the position after the operation. i_cfg writes smooth_time; it is always ready
// and is to be written only while the unit is idle; the block itself does not enforce this.
// Set target: from accept, the unit passes through ST_FIN into the output register.
// Advance: a bit-serial division for omega, five products for the denominator, a second
// division for its reciprocal, then five products for the new velocity and position,
// all through one 32x32 multiplier.
// i_in.ready is high only in idle; one word is in flight at a time. The output register
// holds a finished word until taken, and the next word is accepted meanwhile; a finished
// advance waits in its last step while the output register is still full.
// Reset (synchronous, active low) clears position, goal and velocity and sets smooth_time
// to 50.0; no result is pending after reset.
// Depends on cds_pkg, cds_ifs, cds_mul, cds_div and the assertion macro header.
`include "critically_damped_smoother_unit_defines.svh"
module critically_damped_smoother_unit #(
    parameter int FRAC_BITS = cds_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cds_cfg_if.sink     i_cfg,
    cds_in_if.sink      i_in,
    cds_out_if.source   o_out
);
    import cds_pkg::*;

    localparam int DVD_W = 2 * FRAC_BITS + 2;

    localparam logic signed [Q_W-1:0] ONE_Q = Q_W'(64'd1 << FRAC_BITS);
    localparam logic signed [Q_W-1:0] C_048 =
        Q_W'(((64'd48 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic signed [Q_W-1:0] C_0235 =
        Q_W'(((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [TIME_W-1:0] SMOOTH_RESET = TIME_W'(64'd50 << FRAC_BITS);
    localparam logic [DVD_W-1:0] DVD_OMEGA = {1'b1, {(DVD_W-1){1'b0}}};
    localparam logic [DVD_W-1:0] DVD_E     = {2'b01, {(DVD_W-2){1'b0}}};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OMEGA = 4'd1;
    localparam logic [3:0] ST_X     = 4'd2;
    localparam logic [3:0] ST_X2    = 4'd3;
    localparam logic [3:0] ST_X3    = 4'd4;
    localparam logic [3:0] ST_CA    = 4'd5;
    localparam logic [3:0] ST_CB    = 4'd6;
    localparam logic [3:0] ST_E     = 4'd7;
    localparam logic [3:0] ST_OC    = 4'd8;
    localparam logic [3:0] ST_TEMP  = 4'd9;
    localparam logic [3:0] ST_OT    = 4'd10;
    localparam logic [3:0] ST_NV    = 4'd11;
    localparam logic [3:0] ST_NP    = 4'd12;
    localparam logic [3:0] ST_FIN   = 4'd13;

    logic [3:0]                 r_state;
    logic [3:0]                 n_state;
    logic                       r_launch;
    logic                       r_out_valid;
    logic signed [POS_W-1:0]    r_out_pos;
    logic [TIME_W-1:0]          r_smooth;
    logic signed [POS_W-1:0]    r_cur;
    logic signed [POS_W-1:0]    r_tgt;
    logic signed [VEL_W-1:0]    r_vel;

    logic [TIME_W-1:0]          r_el;
    logic signed [POS_W:0]      r_chg;
    logic signed [Q_W-1:0]      r_omega;
    logic signed [Q_W-1:0]      r_x;
    logic signed [Q_W-1:0]      r_x2;
    logic signed [Q_W-1:0]      r_den;
    logic signed [Q_W-1:0]      r_e;
    logic signed [Q_W-1:0]      r_temp;

    logic                       w_in_fire;
    logic                       w_out_load;
    logic                       w_mul_st;
    logic                       w_div_st;
    logic                       w_mul_start;
    logic                       w_div_start;
    logic                       w_mul_done;
    logic                       w_div_done;
    logic                       w_done;
    logic signed [Q_W-1:0]      w_mul_a;
    logic signed [Q_W-1:0]      w_mul_b;
    logic signed [Q_W-1:0]      w_mul_res;
    logic [DVD_W-1:0]           w_dvd;
    logic [Q_W-1:0]             w_dvs;
    logic [DVD_W-1:0]           w_quot;
    logic signed [Q_W-1:0]      w_quot_q;
    logic signed [Q_W-1:0]      w_el_q;
    logic signed [Q_W-1:0]      w_vel_q;
    logic signed [Q_W-1:0]      w_chg_q;
    logic signed [Q_W-1:0]      w_tgt_q;
    logic signed [POS_W:0]      w_new_dir;
    logic signed [POS_W:0]      w_old_dir;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);

    assign w_el_q   = $signed({{(Q_W-TIME_W){1'b0}}, r_el});
    assign w_vel_q  = $signed({{(Q_W-VEL_W){r_vel[VEL_W-1]}}, r_vel});
    assign w_chg_q  = $signed({{(Q_W-POS_W-1){r_chg[POS_W]}}, r_chg});
    assign w_tgt_q  = $signed({{(Q_W-POS_W){r_tgt[POS_W-1]}}, r_tgt});
    assign w_quot_q = $signed({{(Q_W-DVD_W){1'b0}}, w_quot});

    // sign of travel; a zero difference counts as positive
    assign w_new_dir = $signed({i_in.data.goal_pos[POS_W-1], i_in.data.goal_pos})
                     - $signed({i_in.data.start_pos[POS_W-1], i_in.data.start_pos});
    assign w_old_dir = $signed({r_tgt[POS_W-1], r_tgt}) - $signed({r_cur[POS_W-1], r_cur});

    always_comb begin
        w_mul_st = r_state inside {ST_X, ST_X2, ST_X3, ST_CA, ST_CB,
                                   ST_OC, ST_TEMP, ST_OT, ST_NV, ST_NP};
        w_div_st = r_state inside {ST_OMEGA, ST_E};
    end

    assign w_mul_start = r_launch && w_mul_st;
    assign w_div_start = r_launch && w_div_st;
    assign w_done      = (w_mul_st && w_mul_done) || (w_div_st && w_div_done);

    always_comb begin
        case (r_state)
            ST_X:    begin w_mul_a = r_omega; w_mul_b = w_el_q;  end
            ST_X2:   begin w_mul_a = r_x;     w_mul_b = r_x;     end
            ST_X3:   begin w_mul_a = r_x2;    w_mul_b = r_x;     end
            ST_CA:   begin w_mul_a = C_048;   w_mul_b = r_x2;    end
            ST_CB:   begin w_mul_a = C_0235;  w_mul_b = r_x;     end
            ST_OC:   begin w_mul_a = r_omega; w_mul_b = w_chg_q; end
            ST_TEMP: begin w_mul_a = r_x;     w_mul_b = w_el_q;  end
            ST_OT:   begin w_mul_a = r_omega; w_mul_b = r_temp;  end
            ST_NV:   begin w_mul_a = r_x;     w_mul_b = r_e;     end
            ST_NP:   begin w_mul_a = r_x;     w_mul_b = r_e;     end
            default: begin w_mul_a = '0;      w_mul_b = '0;      end
        endcase
    end

    always_comb begin
        if (r_state == ST_OMEGA) begin
            w_dvd = DVD_OMEGA;
            // a zero smoothing time acts as the smallest step
            w_dvs = {{(Q_W-TIME_W){1'b0}}, (r_smooth == '0) ? TIME_W'(1) : r_smooth};
        end else begin
            w_dvd = DVD_E;
            w_dvs = Q_W'(r_den);
        end
    end

    always_comb begin
        case (r_state)
            ST_OMEGA: n_state = ST_X;
            ST_X:     n_state = ST_X2;
            ST_X2:    n_state = ST_X3;
            ST_X3:    n_state = ST_CA;
            ST_CA:    n_state = ST_CB;
            ST_CB:    n_state = ST_E;
            ST_E:     n_state = ST_OC;
            ST_OC:    n_state = ST_TEMP;
            ST_TEMP:  n_state = ST_OT;
            ST_OT:    n_state = ST_NV;
            ST_NV:    n_state = ST_NP;
            ST_NP:    n_state = ST_FIN;
            default:  n_state = ST_IDLE;
        endcase
    end

    cds_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    cds_div #(
        .FRAC_BITS (FRAC_BITS),
        .DVD_W     (DVD_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_smooth    <= SMOOTH_RESET;
            r_cur       <= '0;
            r_tgt       <= '0;
            r_vel       <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_smooth <= i_cfg.data;
            end
            // a load in the same cycle as a take keeps the register full
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        if (i_in.data.op == OP_SET) begin
                            if (i_in.data.clear_velocity) begin
                                r_vel <= '0;
                            end else if (w_new_dir[POS_W] != w_old_dir[POS_W]) begin
                                r_vel <= vel_neg(r_vel);
                            end
                            r_cur   <= i_in.data.start_pos;
                            r_tgt   <= i_in.data.goal_pos;
                            r_state <= ST_FIN;
                        end else begin
                            r_state  <= ST_OMEGA;
                            r_launch <= 1'b1;
                        end
                    end
                end
                ST_FIN: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    if (r_launch) begin
                        r_launch <= 1'b0;
                    end
                    if (w_done) begin
                        r_state  <= n_state;
                        r_launch <= (n_state != ST_FIN);
                        if (r_state == ST_NV) begin
                            r_vel <= sat_vel(w_mul_res);
                        end
                        if (r_state == ST_NP) begin
                            r_cur <= sat_pos(qadd(w_tgt_q, w_mul_res));
                        end
                    end
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pos <= r_cur;
        end
        if (w_in_fire && i_in.data.op == OP_ADV) begin
            r_el  <= i_in.data.elapsed;
            r_chg <= $signed({r_cur[POS_W-1], r_cur}) - $signed({r_tgt[POS_W-1], r_tgt});
        end
        if (w_done) begin
            case (r_state)
                ST_OMEGA: r_omega <= w_quot_q;
                ST_X: begin
                    r_x   <= w_mul_res;
                    r_den <= qadd(ONE_Q, w_mul_res);
                end
                ST_X2:    r_x2  <= w_mul_res;
                ST_X3:    r_x   <= w_mul_res;
                // all terms of the denominator are non-negative, so summing in
                // sequence saturates the same as the grouped sum
                ST_CA:    r_den <= qadd(r_den, w_mul_res);
                ST_CB:    r_den <= qadd(r_den, w_mul_res);
                ST_E:     r_e   <= w_quot_q;
                ST_OC:    r_x   <= qadd(w_vel_q, w_mul_res);
                ST_TEMP:  r_temp <= w_mul_res;
                ST_OT:    r_x   <= qsub(w_vel_q, w_mul_res);
                ST_NV:    r_x   <= qadd(w_chg_q, r_temp);
                default: begin
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.data.position = r_out_pos;

    `CDS_ASSERT_NEVER(a_one_unit, i_clk, i_rst_n, (w_mul_start && w_div_start), "both units started")
    `CDS_ASSERT(a_adv_enters, i_clk, i_rst_n, (w_in_fire && i_in.data.op == OP_ADV |=> r_state == ST_OMEGA && r_launch), "advance did not start")
    `CDS_ASSERT(a_fin_loads, i_clk, i_rst_n, (w_out_load |=> r_out_valid && r_state == ST_IDLE), "result not loaded")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for critically_damped_smoother_unit.
// Holds a fixed-point predictor of the smoother, drives directed and random input words and
// config writes, and checks each result word. Depends on cds_pkg and cds_ifs.
`timescale 1ns / 1ps
module tb_top;
    import cds_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam longint Q_LIM = (longint'(1) <<< 62) - 1;
    localparam longint Q_ONE = longint'(1) <<< FRAC;
    // 0.48 and 0.235 rounded to nearest at FRAC fraction bits
    localparam longint K_048 = ((longint'(48) <<< FRAC) + 50) / 100;
    localparam longint K_0235 = ((longint'(235) <<< FRAC) + 500) / 1000;
    localparam longint VEL_HI = (longint'(1) <<< (VEL_W - 1)) - 1;
    localparam longint VEL_LO = -(longint'(1) <<< (VEL_W - 1));
    localparam logic signed [POS_W-1:0] POS_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_BOT = 32'sh8000_0000;
    localparam logic [TIME_W-1:0] SMOOTH_RST = 32'h0032_0000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_WORDS = 213;

    typedef enum logic [2:0] {
        CMD_WORD,
        CMD_SMOOTH,
        CMD_DRAIN,
        CMD_HOLD,
        CMD_PACE
    } t_cmd_kind;

    typedef enum logic [1:0] {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FREE
    } t_pace;

    typedef struct packed {
        t_cmd_kind   kind;
        t_in_word    word;
        logic [31:0] arg;
    } t_cmd;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cds_cfg_if cfg_ch ();
    cds_in_if  in_ch ();
    cds_out_if out_ch ();

    critically_damped_smoother_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cmd                    stim_q[$];
    logic signed [POS_W-1:0] expected_positions[$];
    int                      accepted_words;
    int                      returned_words;
    int                      src_idle_pct;
    int                      snk_idle_pct;
    int                      hold_left;
    logic                    stall_req;
    int                      fault_count = 0;

    // tracked smoother state
    longint                  trk_pos;
    longint                  trk_goal;
    longint                  trk_vel;
    logic [TIME_W-1:0]       trk_smooth;

    always begin
        #1 i_clk = ~i_clk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint sat_sum(input longint a, input longint b);
        return clip(a + b, -Q_LIM, Q_LIM);
    endfunction

    // magnitude product, truncated by FRAC bits, clamped, sign restored
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] prod;
        longint       mag;
        prod = {64'd0, (a < 0) ? -a : a} * {64'd0, (b < 0) ? -b : b};
        prod = prod >> FRAC;
        mag = (prod > {64'd0, Q_LIM}) ? Q_LIM : longint'(prod[63:0]);
        return ((a < 0) != (b < 0)) ? -mag : mag;
    endfunction

    function automatic logic signed [POS_W-1:0] predict_position(input t_in_word w);
        longint      from;
        longint      to;
        longint      dt;
        longint      omega;
        longint      x;
        longint      x2;
        longint      x3;
        longint      den;
        longint      gain;
        longint      change;
        longint      temp;
        longint      nv;
        longint      np;
        logic [63:0] st;
        logic        dir_new;
        logic        dir_old;
        if (w.op == OP_SET) begin
            from = longint'(w.start_pos);
            to = longint'(w.goal_pos);
            if (w.clear_velocity) begin
                trk_vel = 0;
            end else begin
                // zero distance counts as positive direction
                dir_new = (to - from) >= 0;
                dir_old = (trk_goal - trk_pos) >= 0;
                if (dir_new != dir_old) begin
                    trk_vel = clip(-trk_vel, VEL_LO, VEL_HI);
                end
            end
            trk_pos = from;
            trk_goal = to;
        end else begin
            st = (trk_smooth == '0) ? 64'd1 : {32'd0, trk_smooth};
            dt = longint'({32'd0, w.elapsed});
            omega = clip(longint'((64'd2 << (2 * FRAC)) / st), 0, Q_LIM);
            x = fx_mul(omega, dt);
            x2 = fx_mul(x, x);
            x3 = fx_mul(x2, x);
            den = sat_sum(sat_sum(Q_ONE, x), sat_sum(fx_mul(K_048, x2), fx_mul(K_0235, x3)));
            gain = longint'((64'd1 << (2 * FRAC)) / 64'(den));
            change = trk_pos - trk_goal;
            temp = fx_mul(sat_sum(trk_vel, fx_mul(omega, change)), dt);
            nv = fx_mul(sat_sum(trk_vel, -fx_mul(omega, temp)), gain);
            np = sat_sum(trk_goal, fx_mul(sat_sum(change, temp), gain));
            trk_vel = clip(nv, VEL_LO, VEL_HI);
            trk_pos = clip(np, longint'(POS_BOT), longint'(POS_TOP));
        end
        return trk_pos[POS_W-1:0];
    endfunction

    // source side: words and config writes from the command queue
    always @(posedge i_clk) begin : drive_proc
        logic took_word;
        logic word_busy;
        logic all_back;
        logic drive_valid;
        logic drive_cfg;
        logic pulse_hold;
        t_cmd head;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.data <= '0;
            stall_req <= 1'b0;
            accepted_words <= 0;
            src_idle_pct <= 0;
            snk_idle_pct <= 0;
            trk_pos = 0;
            trk_goal = 0;
            trk_vel = 0;
            trk_smooth = SMOOTH_RST;
        end else begin
            took_word = in_ch.valid && in_ch.ready;
            if (took_word) begin
                expected_positions.push_back(predict_position(in_ch.data));
                accepted_words <= accepted_words + 1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                trk_smooth = cfg_ch.data;
            end
            word_busy = in_ch.valid && !in_ch.ready;
            all_back = !in_ch.valid && (accepted_words == returned_words);
            drive_valid = word_busy;
            drive_cfg = cfg_ch.valid && !cfg_ch.ready;
            pulse_hold = 1'b0;
            if (!word_busy && !drive_cfg && stim_q.size() != 0) begin
                head = stim_q[0];
                case (head.kind)
                    CMD_WORD: begin
                        if ($urandom_range(0, 99) >= src_idle_pct) begin
                            in_ch.data <= head.word;
                            drive_valid = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    CMD_SMOOTH: begin
                        // config only while nothing is in flight
                        if (all_back) begin
                            cfg_ch.data <= head.arg;
                            drive_cfg = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end
                    CMD_DRAIN: begin
                        if (all_back) begin
                            void'(stim_q.pop_front());
                        end
                    end
                    CMD_HOLD: begin
                        pulse_hold = 1'b1;
                        void'(stim_q.pop_front());
                    end
                    CMD_PACE: begin
                        case (t_pace'(head.arg[1:0]))
                            PACE_SLOW_SINK: begin
                                src_idle_pct <= 25;
                                snk_idle_pct <= 88;
                            end
                            PACE_SLOW_SOURCE: begin
                                src_idle_pct <= 88;
                                snk_idle_pct <= 25;
                            end
                            default: begin
                                src_idle_pct <= 0;
                                snk_idle_pct <= 0;
                            end
                        endcase
                        void'(stim_q.pop_front());
                    end
                    default: begin
                        void'(stim_q.pop_front());
                    end
                endcase
            end
            in_ch.valid <= drive_valid;
            cfg_ch.valid <= drive_cfg;
            stall_req <= pulse_hold;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (stall_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // sink side: take result words and compare
    always @(posedge i_clk) begin : sink_proc
        logic signed [POS_W-1:0] want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            returned_words <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                returned_words <= returned_words + 1;
                if (expected_positions.size() == 0) begin
                    $error("unexpected result word: position %0d", out_ch.data.position);
                    fault_count++;
                end else begin
                    want = expected_positions.pop_front();
                    if (out_ch.data.position !== want) begin
                        $error("position mismatch: expected %0d, got %0d",
                               want, out_ch.data.position);
                        fault_count++;
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    task automatic queue_cmd(input t_cmd_kind kind, input logic [31:0] arg);
        t_cmd c;
        c = '0;
        c.kind = kind;
        c.arg = arg;
        stim_q.push_back(c);
    endtask

    task automatic queue_word(input logic op, input logic signed [POS_W-1:0] from,
                              input logic signed [POS_W-1:0] to, input logic clr,
                              input logic [TIME_W-1:0] dt);
        t_cmd c;
        c = '0;
        c.kind = CMD_WORD;
        c.word.op = op;
        c.word.start_pos = from;
        c.word.goal_pos = to;
        c.word.clear_velocity = clr;
        c.word.elapsed = dt;
        stim_q.push_back(c);
    endtask

    function automatic logic signed [POS_W-1:0] pick_pos();
        logic [31:0] r;
        case ($urandom_range(0, 5))
            0: r = $urandom;
            1: r = POS_TOP;
            2: r = POS_BOT;
            default: r = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
        endcase
        return $signed(r);
    endfunction

    initial begin : main_proc
        logic [TIME_W-1:0] smooth_arg;
        logic [TIME_W-1:0] dt;
        logic              op;
        i_rst_n = 1'b0;

        // directed: reset smooth time first
        queue_cmd(CMD_PACE, 32'(PACE_SLOW_SINK));
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h0001_0000);
        queue_word(OP_SET, POS_BOT, POS_TOP, 1'b0, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'hFFFF_FFFF);
        // direction flip negates velocity
        queue_word(OP_SET, POS_TOP, POS_BOT, 1'b0, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h0001_0000);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h0004_0000);
        // equal start and goal: direction counts as positive
        queue_word(OP_SET, 32'sh0005_0000, 32'sh0005_0000, 1'b0, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h0000_8000);
        queue_word(OP_SET, 0, 32'shFFFF_FFFF, 1'b1, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h0001_0000);
        // smooth time of zero acts as the smallest step
        queue_cmd(CMD_SMOOTH, 32'h0);
        queue_word(OP_SET, POS_TOP, POS_BOT, 1'b1, 32'h0);
        // drives velocity to its negative limit, then a flip must saturate
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h1);
        queue_word(OP_SET, 32'shFFFF_0000, 32'sh0001_0000, 1'b0, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h1);
        queue_cmd(CMD_SMOOTH, 32'h1);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'hFFFF_FFFF);
        queue_word(OP_SET, 32'sh0001_0000, 32'shFFFF_0000, 1'b0, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'h0001_0000);
        queue_cmd(CMD_SMOOTH, 32'hFFFF_FFFF);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'hFFFF_FFFF);
        queue_word(OP_SET, POS_BOT, POS_TOP, 1'b1, 32'h0);
        queue_word(OP_ADV, 0, 0, 1'b0, 32'hFFFF_FFFF);

        // random phases: a smooth time each, then set-target words scattered among runs of advances
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: smooth_arg = 32'hFFFF_FFFF;
                1: smooth_arg = 32'h0000_0001;
                2: smooth_arg = 32'h0001_0000;
                3: smooth_arg = SMOOTH_RST;
                4: smooth_arg = $urandom_range(1, 32'h0100_0000);
                default: smooth_arg = 32'h0000_4000;
            endcase
            queue_cmd(CMD_SMOOTH, smooth_arg);
            queue_cmd(CMD_PACE, (p < 2) ? 32'(PACE_SLOW_SINK) :
                                (p < 4) ? 32'(PACE_SLOW_SOURCE) : 32'(PACE_FREE));
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 5 && n == 10) begin
                    queue_cmd(CMD_HOLD, 32'h0);
                end
                if (p == 3 && n == 100) begin
                    queue_cmd(CMD_DRAIN, 32'h0);
                end
                op = ($urandom_range(0, 99) < 15) ? OP_SET : OP_ADV;
                case ($urandom_range(0, 9))
                    0: dt = 32'h0;
                    1: dt = 32'hFFFF_FFFF;
                    2: dt = $urandom;
                    3: dt = $urandom_range(0, 32'h0000_FFFF);
                    default: dt = $urandom_range(0, 32'h0004_0000);
                endcase
                queue_word(op, pick_pos(), pick_pos(), 1'($urandom_range(0, 1)), dt);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (stim_q.size() != 0 || in_ch.valid || cfg_ch.valid ||
                   accepted_words != returned_words);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_positions.size() != 0) begin
            $error("%0d expected result words never arrived", expected_positions.size());
        end
        if (fault_count == 0 && expected_positions.size() == 0) begin
            $display("critically_damped_smoother_unit regression: pass");
        end else begin
            $display("critically_damped_smoother_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("critically_damped_smoother_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/cds_pkg.sv
hw/rtl/cds_ifs.sv
hw/rtl/cds_mul.sv
hw/rtl/cds_div.sv
hw/rtl/critically_damped_smoother_unit.sv
tb/tb_top.sv
